@@ hw/rtl/tkpc_pkg.sv @@
// Package for the touch key press classifier.
// Holds shared sizes, reset values and the lane control and event types.
// No dependencies.
package tkpc_pkg;

    localparam int KEYS_MAX      = 4;
    localparam int NUM_KEYS_DEF  = 4;
    localparam int CNT_W         = 8;
    localparam int FRAME_W       = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd100;
    localparam logic [CNT_W-1:0] CNT_SAT     = 8'hFF;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    typedef struct packed {
        logic             fire;
        logic             tick;
        logic             scan;
        logic             take;
        logic [CNT_W-1:0] limit;
    } t_lane_ctl;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } t_lane_ev;

endpackage

@@ hw/rtl/tkpc_frame_check.sv @@
// Frame checker for the touch key press classifier.
// Counts touched key bits and matches them against the count field and valid flag.
// Depends on tkpc_pkg.
module tkpc_frame_check (
    input  logic [tkpc_pkg::FRAME_W-1:0] i_frame,
    input  logic                         i_present,
    output logic                         o_ok
);

    logic [2:0] zeros;

    always_comb begin
        zeros = 3'd0;
        for (int k = 0; k < tkpc_pkg::KEYS_MAX; k++) begin
            zeros = zeros + {2'b00, ~i_frame[k]};
        end
    end

    assign o_ok = i_present && (zeros == i_frame[6:4]) && i_frame[7];

endmodule

@@ hw/rtl/tkpc_key_lane.sv @@
// One key lane of the touch key press classifier.
// Holds the press marks and hold counter of one key and classifies it on each scan.
// Depends on tkpc_pkg.
module tkpc_key_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tkpc_pkg::t_lane_ctl  i_ctl,
    input  logic                 i_level,
    output tkpc_pkg::t_lane_ev   o_ev
);

    logic                         r_pressed, r_released, r_timing;
    logic [tkpc_pkg::CNT_W-1:0]   r_count;
    logic                         n_pressed, n_released, n_timing;
    logic [tkpc_pkg::CNT_W-1:0]   n_count;
    logic                         p1, rl1, t1;
    logic [tkpc_pkg::CNT_W-1:0]   c1;
    logic                         long_ev, short_ev;

    always_comb begin
        p1  = r_pressed;
        rl1 = r_released;
        t1  = r_timing;
        c1  = r_count;
        if (i_ctl.take) begin
            if (i_level && r_pressed) begin
                rl1 = 1'b1;
                t1  = 1'b0;
                c1  = '0;
            end else if (!i_level) begin
                p1  = 1'b1;
                rl1 = 1'b0;
                t1  = 1'b1;
                c1  = '0;
            end
        end
        long_ev  = t1 && (c1 > i_ctl.limit) && p1;
        short_ev = !long_ev && (c1 < i_ctl.limit) && p1 && rl1;

        n_pressed  = r_pressed;
        n_released = r_released;
        n_timing   = r_timing;
        n_count    = r_count;
        if (i_ctl.tick) begin
            if (r_timing && (r_count != tkpc_pkg::CNT_SAT)) begin
                n_count = r_count + 1'b1;
            end
        end else if (i_ctl.scan) begin
            n_pressed  = p1 && !short_ev;
            n_released = rl1;
            n_timing   = t1;
            n_count    = long_ev ? '0 : c1;
        end
    end

    assign o_ev.short_ev = i_ctl.scan && short_ev;
    assign o_ev.long_ev  = i_ctl.scan && long_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= 1'b0;
            r_released <= 1'b1;
            r_timing   <= 1'b0;
            r_count    <= '0;
        end else if (i_ctl.fire) begin
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_timing   <= n_timing;
            r_count    <= n_count;
        end
    end

endmodule

@@ hw/rtl/tkpc_merge.sv @@
// Merge stage of the touch key press classifier.
// Stores key levels, gathers lane events and holds the result word for the output.
// Depends on tkpc_pkg.
module tkpc_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic                              i_load_levels,
    input  logic [tkpc_pkg::KEYS_MAX-1:0]     i_levels,
    input  logic                              i_ok,
    input  tkpc_pkg::t_lane_ev [tkpc_pkg::KEYS_MAX-1:0] i_ev,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [tkpc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_room
);

    logic [tkpc_pkg::KEYS_MAX-1:0]    r_levels, n_levels;
    logic [tkpc_pkg::KEYS_MAX-1:0]    shorts, longs;
    logic                             r_valid;
    logic [tkpc_pkg::OUT_TDATA_W-1:0] r_data;
    logic                             r_ok;

    always_comb begin
        for (int k = 0; k < tkpc_pkg::KEYS_MAX; k++) begin
            shorts[k] = i_ev[k].short_ev;
            longs[k]  = i_ev[k].long_ev;
        end
        n_levels = i_load_levels ? i_levels : r_levels;
    end

    assign o_room     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '1;
            r_valid  <= 1'b0;
        end else begin
            if (i_fire) begin
                r_levels <= n_levels;
                r_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= {4'b0000, longs, shorts, n_levels};
            r_ok   <= i_ok;
        end
    end

endmodule

@@ hw/rtl/touch_key_press_classifier_top.sv @@
// Top level of the touch key press classifier.
// Instantiates the frame checker, one lane per key and the merge stage.
// Depends on tkpc_pkg, tkpc_frame_check, tkpc_key_lane and tkpc_merge.
//
// Usage:
//   Slave channel: one word per timer tick or scan. tuser[0] selects the kind
//   (0 tick, 1 scan), tuser[1] marks a scan that carries a frame, tdata holds
//   the raw touch frame.
//   Master channel: one word per accepted input word. tuser is frame_ok,
//   tdata carries key levels, short press mask and long press mask.
//   Config: i_cfg_we writes the long press limit from i_cfg_wdata; write it
//   only while no word is in flight.
//   The result word is registered: it is loaded into the output register
//   at the accepting edge and is offered in the cycle after. Throughput is
//   one word per cycle while the receiver is ready, set by the single output
//   register; all key lanes work in parallel in the accepting cycle.
//   When the receiver stalls, the output register holds its word and the
//   slave side takes a new word only in a cycle where that word leaves.
//   Reset sets all key lanes to released and not timing, sets all levels up,
//   sets the limit to 100 and empties the output register; no clearing pass is needed.
module touch_key_press_classifier_top #(
    parameter int NUM_KEYS = tkpc_pkg::NUM_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tkpc_pkg::FRAME_W-1:0]      i_s_tdata,  // frame[7:0]
    input  logic [1:0]                        i_s_tuser,  // action, frame_present
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tkpc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // key_levels, short_events,
                                                          // long_events, zero pad
    output logic                              o_m_tuser,  // frame_ok
    input  logic                              i_cfg_we,
    input  logic [tkpc_pkg::CNT_W-1:0]        i_cfg_wdata
);

    logic [tkpc_pkg::CNT_W-1:0]   r_limit_val;
    logic                         room, fire, is_scan, is_tick, present, ok;
    tkpc_pkg::t_lane_ctl          ctl;
    tkpc_pkg::t_lane_ev [tkpc_pkg::KEYS_MAX-1:0] ev;

    assign o_s_tready = room;
    assign fire       = i_s_tvalid && room;
    assign is_scan    = (i_s_tuser[0] == tkpc_pkg::ACT_SCAN);
    assign is_tick    = (i_s_tuser[0] == tkpc_pkg::ACT_TICK);
    assign present    = is_scan && i_s_tuser[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_val <= tkpc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit_val <= i_cfg_wdata;
        end
    end

    tkpc_frame_check u_check (
        .i_frame   (i_s_tdata),
        .i_present (present),
        .o_ok      (ok)
    );

    assign ctl.fire  = fire;
    assign ctl.tick  = fire && is_tick;
    assign ctl.scan  = fire && is_scan;
    assign ctl.take  = ok;
    assign ctl.limit = r_limit_val;

    for (genvar k = 0; k < tkpc_pkg::KEYS_MAX; k++) begin : g_lane
        if (k < NUM_KEYS) begin : g_used
            tkpc_key_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_level (i_s_tdata[k]),
                .o_ev    (ev[k])
            );
        end else begin : g_unused
            assign ev[k] = '0;
        end
    end

    tkpc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_load_levels (present),
        .i_levels      (i_s_tdata[tkpc_pkg::KEYS_MAX-1:0]),
        .i_ok          (ok),
        .i_ev          (ev),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_room        (room)
    );

endmodule
